// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");
`else
`define ASSERT_HOLDS(label, clk, rst, expr)
`define ASSERT_NEXT(label, clk, rst, cond, expr)
`endif
`endif

// File: hw/rtl/ptpba_pkg.sv
// ---------------------------------------------------------------------------
// Page block allocator package
// Defaults, field widths, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package ptpba_pkg;

   localparam int DEF_NUM_PAGES       = 8;
   localparam int DEF_PAGE_BYTES      = 256;
   localparam int DEF_MIN_BLOCK_BYTES = 16;
   localparam int DEF_NUM_CLASSES     = 5;

   localparam int ACTION_W = 2;
   localparam int REQ_W    = 16;
   localparam int OFF_W    = 11;
   localparam int STATUS_W = 3;
   localparam int CFG_W    = 24;
   localparam int CODE_W   = 3;

   localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_INIT  = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK   = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_ZERO = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_OOM  = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_BAD  = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_FULL = 3'd4;

   typedef struct packed {
      logic capture;
      logic execute;
      logic init_step;
   } dp_cmd_type;

   typedef struct packed {
      logic act_init;
      logic init_last;
   } dp_stat_type;

endpackage

// File: hw/rtl/ptpba_ctrl.sv
// ---------------------------------------------------------------------------
// Page block allocator controller
// Sequences capture, execution, the init walk and the response beat.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ptpba_ctrl
   import ptpba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output logic        rsp_valid,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_INIT = 4'b0100,
      ST_RESP = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign busy      = (state_ff == ST_EXEC) || (state_ff == ST_INIT);
   assign accept    = start && !busy;
   assign rsp_valid = (state_ff == ST_RESP);

   assign cmd.capture   = accept;
   assign cmd.execute   = (state_ff == ST_EXEC);
   assign cmd.init_step = (state_ff == ST_INIT);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = stat.act_init ? ST_INIT : ST_RESP;
         end
         ST_INIT: begin
            if (stat.init_last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = accept ? ST_EXEC : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid)
   `ASSERT_NEXT(a_exec_resp, clock, reset, (state_ff == ST_EXEC) && !stat.act_init, rsp_valid)

endmodule

// File: hw/rtl/ptpba_dp.sv
// ---------------------------------------------------------------------------
// Page block allocator datapath
// Free-list memory, list heads and counts, page class decode and init walk.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ptpba_dp
   import ptpba_pkg::*;
#(
   parameter int NUM_PAGES       = DEF_NUM_PAGES,
   parameter int PAGE_BYTES      = DEF_PAGE_BYTES,
   parameter int MIN_BLOCK_BYTES = DEF_MIN_BLOCK_BYTES,
   parameter int NUM_CLASSES     = DEF_NUM_CLASSES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [REQ_W-1:0]    req_request_bytes,
   input  logic [OFF_W-1:0]    req_block_offset,
   input  logic                csr_we,
   input  logic [CFG_W-1:0]    csr_wdata,
   input  dp_cmd_type          cmd,
   output dp_stat_type         stat,
   output logic [OFF_W-1:0]    rsp_granted_offset,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int ARENA_BYTES     = NUM_PAGES * PAGE_BYTES;
   localparam int RAW_DEPTH       = ARENA_BYTES / MIN_BLOCK_BYTES;
   localparam int LIST_DEPTH      = (RAW_DEPTH > 0) ? RAW_DEPTH : 1;
   localparam int IDX_W           = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W           = $clog2(LIST_DEPTH + 1);
   localparam int TAIL_W          = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
   localparam int CLS_W           = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int PG_W            = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int MEM_DEPTH       = NUM_CLASSES * (2 ** IDX_W);
   localparam int ADDR_W          = $clog2(MEM_DEPTH);
   localparam int MAX_CLASS_BYTES = MIN_BLOCK_BYTES * (2 ** (NUM_CLASSES - 1));
   localparam int RAW_SUM_W       = $clog2(ARENA_BYTES + MAX_CLASS_BYTES + 1);
   localparam int SUM_W           = (RAW_SUM_W > REQ_W) ? RAW_SUM_W : REQ_W;

   logic [ACTION_W-1:0] cmd_action_ff;
   logic [REQ_W-1:0]    cmd_req_ff;
   logic [OFF_W-1:0]    cmd_off_ff;
   logic [CFG_W-1:0]    page_classes_ff;
   logic [IDX_W-1:0]    head_ff  [NUM_CLASSES];
   logic [CNT_W-1:0]    count_ff [NUM_CLASSES];
   logic [PG_W-1:0]     walk_page_ff;
   logic [SUM_W-1:0]    walk_base_ff;
   logic [SUM_W-1:0]    walk_inpage_ff;
   logic [OFF_W-1:0]    mem [MEM_DEPTH];
   logic [OFF_W-1:0]    rd_data_ff;
   logic                alloc_ok_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;

   logic [PG_W-1:0]     free_page;
   logic [CLS_W-1:0]    free_class;
   logic [CLS_W-1:0]    walk_class;
   logic [SUM_W-1:0]    walk_size;
   logic [SUM_W-1:0]    walk_next;
   logic                walk_fits;
   logic                off_bad;
   logic                found;
   logic [CLS_W-1:0]    sel_class;
   logic [CLS_W-1:0]    push_class;
   logic [OFF_W-1:0]    push_off;
   logic                push_req;
   logic                push_full;
   logic                push_en;
   logic                pop_en;
   logic [TAIL_W-1:0]   tail_sum;
   logic [IDX_W-1:0]    tail_idx;
   logic [ADDR_W-1:0]   waddr;
   logic [ADDR_W-1:0]   raddr;
   logic                act_alloc;
   logic                act_free;

   function automatic logic [SUM_W-1:0] class_bytes(input logic [CLS_W-1:0] c);
      return SUM_W'(MIN_BLOCK_BYTES) << c;
   endfunction

   function automatic logic [CLS_W-1:0] page_class(input logic [CFG_W-1:0] cfg,
                                                   input logic [PG_W-1:0] pg);
      logic [CODE_W-1:0] code;
      code = '0;
      for (int p = 0; p < NUM_PAGES; p++) begin
         if (pg == PG_W'(p)) begin
            code = cfg[CODE_W*p +: CODE_W];
         end
      end
      if (int'(code) >= NUM_CLASSES) begin
         return CLS_W'(NUM_CLASSES - 1);
      end
      return CLS_W'(code);
   endfunction

   assign act_alloc = (cmd_action_ff == ACT_ALLOC);
   assign act_free  = (cmd_action_ff == ACT_FREE);

   always_comb begin
      free_page = '0;
      for (int p = 1; p < NUM_PAGES; p++) begin
         if (SUM_W'(cmd_off_ff) >= SUM_W'(p * PAGE_BYTES)) begin
            free_page = PG_W'(p);
         end
      end
   end

   assign off_bad    = SUM_W'(cmd_off_ff) >= SUM_W'(ARENA_BYTES);
   assign free_class = page_class(page_classes_ff, free_page);
   assign walk_class = page_class(page_classes_ff, walk_page_ff);
   assign walk_size  = class_bytes(walk_class);
   assign walk_next  = walk_inpage_ff + walk_size;
   assign walk_fits  = walk_next <= SUM_W'(PAGE_BYTES);

   always_comb begin
      found     = 1'b0;
      sel_class = '0;
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if ((SUM_W'(cmd_req_ff) <= class_bytes(CLS_W'(c))) && (count_ff[c] != '0)) begin
            found     = 1'b1;
            sel_class = CLS_W'(c);
         end
      end
   end

   assign push_class = cmd.init_step ? walk_class : free_class;
   assign push_off   = cmd.init_step ? OFF_W'(walk_base_ff + walk_inpage_ff) : cmd_off_ff;
   assign push_req   = (cmd.execute && act_free && !off_bad) || (cmd.init_step && walk_fits);
   assign push_full  = (count_ff[push_class] == CNT_W'(LIST_DEPTH));
   assign push_en    = push_req && !push_full;
   assign pop_en     = cmd.execute && act_alloc && (cmd_req_ff != '0) && found;

   always_comb begin
      tail_sum = TAIL_W'(head_ff[push_class]) + TAIL_W'(count_ff[push_class]);
      if (tail_sum >= TAIL_W'(LIST_DEPTH)) begin
         tail_sum = tail_sum - TAIL_W'(LIST_DEPTH);
      end
      tail_idx = IDX_W'(tail_sum);
   end

   assign waddr = ADDR_W'({push_class, tail_idx});
   assign raddr = ADDR_W'({sel_class, head_ff[sel_class]});

   always_comb begin
      status_in = STAT_OK;
      case (cmd_action_ff)
         ACT_ALLOC: begin
            if (cmd_req_ff == '0) begin
               status_in = STAT_ZERO;
            end else if (!found) begin
               status_in = STAT_OOM;
            end
         end
         ACT_FREE: begin
            if (off_bad) begin
               status_in = STAT_BAD;
            end else if (push_full) begin
               status_in = STAT_FULL;
            end
         end
         default: begin
            status_in = STAT_OK;
         end
      endcase
   end

   assign stat.act_init  = (cmd_action_ff == ACT_INIT);
   assign stat.init_last = !walk_fits && (walk_page_ff == PG_W'(NUM_PAGES - 1));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_action_ff <= req_action;
         cmd_req_ff    <= req_request_bytes;
         cmd_off_ff    <= req_block_offset;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_classes_ff <= '0;
      end else if (csr_we) begin
         page_classes_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            head_ff[c]  <= '0;
            count_ff[c] <= '0;
         end
      end else if (cmd.execute && stat.act_init) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            head_ff[c]  <= '0;
            count_ff[c] <= '0;
         end
      end else begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            if (pop_en && (sel_class == CLS_W'(c))) begin
               head_ff[c]  <= (head_ff[c] == IDX_W'(LIST_DEPTH - 1)) ? '0 : head_ff[c] + 1'b1;
               count_ff[c] <= count_ff[c] - 1'b1;
            end else if (push_en && (push_class == CLS_W'(c))) begin
               count_ff[c] <= count_ff[c] + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         walk_page_ff   <= '0;
         walk_base_ff   <= '0;
         walk_inpage_ff <= '0;
      end else if (cmd.init_step) begin
         if (walk_fits) begin
            walk_inpage_ff <= walk_next;
         end else begin
            walk_page_ff   <= walk_page_ff + 1'b1;
            walk_base_ff   <= walk_base_ff + SUM_W'(PAGE_BYTES);
            walk_inpage_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         mem[waddr] <= push_off;
      end
      if (pop_en) begin
         rd_data_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff   <= STAT_OK;
         alloc_ok_ff <= 1'b0;
      end else if (cmd.execute) begin
         status_ff   <= status_in;
         alloc_ok_ff <= pop_en;
      end
   end

   assign rsp_granted_offset = alloc_ok_ff ? rd_data_ff : '0;
   assign rsp_status         = status_ff;

   `ASSERT_HOLDS(a_push_pop_excl, clock, reset, !(push_en && pop_en))
   `ASSERT_HOLDS(a_grant_ok, clock, reset, !alloc_ok_ff || (status_ff == STAT_OK))

   for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_count_chk
      `ASSERT_HOLDS(a_count_bound, clock, reset, count_ff[g] <= CNT_W'(LIST_DEPTH))
   end

endmodule

// File: hw/rtl/power_of_two_page_block_allocator.sv
// Allocate, free and unused actions: strobe in the cycle after the execute cycle.
// Init: the execute cycle, then an init walk that pushes every block of each page in turn,
// with a step to the next page after each page's last block, then the strobe.
// A new request is accepted while busy is low, which includes the cycle of the strobe.
// Reset (synchronous): all lists empty and the class register cleared; memory is not cleared.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ---------------------------------------------------------------------------
// Power-of-two page block allocator
// Per-class FIFO free lists of block offsets over an arena of classed pages.
// ---------------------------------------------------------------------------
module power_of_two_page_block_allocator
   import ptpba_pkg::*;
#(
   parameter int NUM_PAGES       = DEF_NUM_PAGES,
   parameter int PAGE_BYTES      = DEF_PAGE_BYTES,
   parameter int MIN_BLOCK_BYTES = DEF_MIN_BLOCK_BYTES,
   parameter int NUM_CLASSES     = DEF_NUM_CLASSES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [REQ_W-1:0]    req_request_bytes,
   input  logic [OFF_W-1:0]    req_block_offset,
   output logic                rsp_valid,
   output logic [OFF_W-1:0]    rsp_granted_offset,
   output logic [STATUS_W-1:0] rsp_status,
   input  logic                csr_we,
   input  logic [CFG_W-1:0]    csr_wdata
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   ptpba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   ptpba_dp #(
      .NUM_PAGES       (NUM_PAGES),
      .PAGE_BYTES      (PAGE_BYTES),
      .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
      .NUM_CLASSES     (NUM_CLASSES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_action         (req_action),
      .req_request_bytes  (req_request_bytes),
      .req_block_offset   (req_block_offset),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_granted_offset (rsp_granted_offset),
      .rsp_status         (rsp_status)
   );

endmodule

// File: verif/testbench.sv
// ---------------------------------------------------------------------------
// Page block allocator testbench
// Drives allocate, free, init and unused commands into the allocator under
// several page class settings. A shadow copy of the per-class free lists
// predicts the granted offset and status of every beat, and each result
// strobe is checked against the oldest prediction.
// ---------------------------------------------------------------------------
module testbench;
   import ptpba_pkg::*;

   localparam int ARENA_BYTES = DEF_NUM_PAGES * DEF_PAGE_BYTES;
   localparam int LIST_DEPTH  = ARENA_BYTES / DEF_MIN_BLOCK_BYTES;
   localparam int STALL_LIMIT = 2000;
   localparam int MAX_REPORTS = 10;
   localparam int MAX_GAP     = 8;
   localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [OFF_W-1:0]    granted;
      logic [STATUS_W-1:0] status;
   } grant_record_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [ACTION_W-1:0] req_action = ACT_ALLOC;
   logic [REQ_W-1:0]    req_request_bytes = '0;
   logic [OFF_W-1:0]    req_block_offset = '0;
   logic                rsp_valid;
   logic [OFF_W-1:0]    rsp_granted_offset;
   logic [STATUS_W-1:0] rsp_status;
   logic                csr_we = 1'b0;
   logic [CFG_W-1:0]    csr_wdata = '0;

   grant_record_type awaited_grants[$];
   logic [OFF_W-1:0] held_blocks[$];
   logic [CFG_W-1:0] shadow_classes = '0;
   logic [OFF_W-1:0] shadow_store[DEF_NUM_CLASSES][LIST_DEPTH];
   int               shadow_head[DEF_NUM_CLASSES];
   int               shadow_count[DEF_NUM_CLASSES];
   int               mismatches = 0;
   int               stall_cycles = 0;
   bit               no_idle = 1'b0;

   power_of_two_page_block_allocator u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_request_bytes  (req_request_bytes),
      .req_block_offset   (req_block_offset),
      .rsp_valid          (rsp_valid),
      .rsp_granted_offset (rsp_granted_offset),
      .rsp_status         (rsp_status),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      for (int c = 0; c < DEF_NUM_CLASSES; c++) begin
         shadow_head[c] = 0;
         shadow_count[c] = 0;
      end
   end

   function automatic int class_of_page(int page);
      int code;
      code = int'((shadow_classes >> (CODE_W * page)) & 24'd7);
      if (code >= DEF_NUM_CLASSES) begin
         code = DEF_NUM_CLASSES - 1;
      end
      return code;
   endfunction

   function automatic bit push_free_block(int cls, logic [OFF_W-1:0] offset);
      if (shadow_count[cls] >= LIST_DEPTH) begin
         return 1'b0;
      end
      shadow_store[cls][(shadow_head[cls] + shadow_count[cls]) % LIST_DEPTH] = offset;
      shadow_count[cls]++;
      return 1'b1;
   endfunction

   function automatic grant_record_type apply_to_free_lists(logic [ACTION_W-1:0] action,
                                                            logic [REQ_W-1:0] bytes,
                                                            logic [OFF_W-1:0] offset);
      grant_record_type result;
      int               size;
      int               cls;
      result.action  = action;
      result.granted = '0;
      result.status  = STAT_OK;
      case (action)
         ACT_ALLOC: begin
            if (bytes == '0) begin
               result.status = STAT_ZERO;
            end else begin
               result.status = STAT_OOM;
               for (int c = 0; c < DEF_NUM_CLASSES; c++) begin
                  if (result.status == STAT_OOM && int'(bytes) <= (DEF_MIN_BLOCK_BYTES << c)
                      && shadow_count[c] > 0) begin
                     result.granted = shadow_store[c][shadow_head[c]];
                     shadow_head[c] = (shadow_head[c] + 1) % LIST_DEPTH;
                     shadow_count[c]--;
                     result.status = STAT_OK;
                  end
               end
            end
         end
         ACT_FREE: begin
            if (int'(offset) >= ARENA_BYTES) begin
               result.status = STAT_BAD;
            end else if (!push_free_block(class_of_page(int'(offset) / DEF_PAGE_BYTES),
                                          offset)) begin
               result.status = STAT_FULL;
            end
         end
         ACT_INIT: begin
            for (int c = 0; c < DEF_NUM_CLASSES; c++) begin
               shadow_head[c] = 0;
               shadow_count[c] = 0;
            end
            for (int p = 0; p < DEF_NUM_PAGES; p++) begin
               cls = class_of_page(p);
               size = DEF_MIN_BLOCK_BYTES << cls;
               for (int k = 0; k < DEF_PAGE_BYTES / size; k++) begin
                  void'(push_free_block(cls, OFF_W'(p * DEF_PAGE_BYTES + k * size)));
               end
            end
         end
         default: begin
         end
      endcase
      return result;
   endfunction

   task automatic note_mismatch(string what, grant_record_type want);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("%s: expected offset %0h status %0d, got offset %0h status %0d",
                  what, want.granted, want.status, rsp_granted_offset, rsp_status);
      end
   endtask

   always @(posedge clock) begin
      grant_record_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (awaited_grants.size() == 0) begin
               want = '0;
               note_mismatch("Result beat with nothing awaited", want);
            end else begin
               want = awaited_grants[0];
               awaited_grants.delete(0);
               if (rsp_granted_offset !== want.granted || rsp_status !== want.status) begin
                  note_mismatch("Result beat mismatch", want);
               end else if (want.action == ACT_ALLOC && want.status == STAT_OK) begin
                  held_blocks.insert(held_blocks.size(), want.granted);
                  if (held_blocks.size() > 256) begin
                     held_blocks.delete(0);
                  end
               end
            end
         end
         if (start && !busy) begin
            awaited_grants.insert(awaited_grants.size(),
               apply_to_free_lists(req_action, req_request_bytes, req_block_offset));
         end
         if (csr_we) begin
            shadow_classes = csr_wdata;
         end
         stall_cycles = (rsp_valid || (start && !busy)) ? 0 : stall_cycles + 1;
      end
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
      end
      $display("== FAIL ==");
      $finish;
   end

   task automatic issue_request(logic [ACTION_W-1:0] action, logic [REQ_W-1:0] bytes,
                                logic [OFF_W-1:0] offset);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start             <= 1'b1;
      req_action        <= action;
      req_request_bytes <= bytes;
      req_block_offset  <= offset;
      do begin
         @(posedge clock);
      end while (busy);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (awaited_grants.size() != 0 || busy) begin
         @(posedge clock);
      end
   endtask

   task automatic write_page_classes(logic [CFG_W-1:0] value);
      drain();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic test_empty_lists();
      issue_request(ACT_ALLOC, 16'd16, 11'h000);
      issue_request(ACT_ALLOC, 16'd0, 11'h7FF);
      issue_request(ACT_FREE, 16'hFFFF, 11'h7FF);
      issue_request(ACT_ALLOC, 16'hFFFF, 11'h000);
      issue_request(ACT_ALLOC, 16'd1, 11'h000);
      issue_request(ACT_NONE, 16'hFFFF, 11'h7FF);
   endtask

   task automatic test_class_fit();
      logic [CFG_W-1:0] codes;
      for (int p = 0; p < DEF_NUM_PAGES; p++) begin
         codes[CODE_W*p +: CODE_W] = CODE_W'(p);
      end
      write_page_classes(codes);
      issue_request(ACT_INIT, 16'h5555, 11'h2AA);
      issue_request(ACT_ALLOC, 16'd16, 11'h000);
      issue_request(ACT_ALLOC, 16'd17, 11'h000);
      issue_request(ACT_ALLOC, 16'd64, 11'h000);
      issue_request(ACT_ALLOC, 16'd129, 11'h000);
      issue_request(ACT_ALLOC, 16'd256, 11'h000);
      issue_request(ACT_ALLOC, 16'd257, 11'h000);
      issue_request(ACT_FREE, 16'd0, 11'h100);
      issue_request(ACT_FREE, 16'd0, 11'h700);
   endtask

   task automatic test_full_list();
      write_page_classes('0);
      issue_request(ACT_INIT, 16'hAAAA, 11'h555);
      issue_request(ACT_FREE, 16'd0, 11'h000);
      issue_request(ACT_ALLOC, 16'd1, 11'h000);
      issue_request(ACT_FREE, 16'd0, 11'h000);
      issue_request(ACT_FREE, 16'd0, 11'h7F0);
   endtask

   task automatic test_largest_class();
      write_page_classes('1);
      issue_request(ACT_INIT, 16'd0, 11'h000);
      for (int k = 0; k <= DEF_NUM_PAGES; k++) begin
         issue_request(ACT_ALLOC, 16'd256, 11'h000);
      end
      issue_request(ACT_FREE, 16'd0, 11'h7FF);
      issue_request(ACT_ALLOC, 16'd200, 11'h000);
      // The class of a page is read at free time, so this free lands in the
      // smallest class even though the lists were built with the largest.
      write_page_classes('0);
      issue_request(ACT_FREE, 16'd0, 11'h400);
      issue_request(ACT_ALLOC, 16'd16, 11'h000);
   endtask

   task automatic test_random_traffic();
      logic [CFG_W-1:0] codes;
      logic [REQ_W-1:0] bytes;
      logic [OFF_W-1:0] offset;
      int               roll;
      int               pick;
      for (int phase = 0; phase < 12; phase++) begin
         case ($urandom_range(0, 5))
            0:       codes = '0;
            1:       codes = '1;
            default: codes = CFG_W'($urandom());
         endcase
         write_page_classes(codes);
         no_idle = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) != 0) begin
            issue_request(ACT_INIT, REQ_W'($urandom()), OFF_W'($urandom()));
         end
         for (int n = 0; n < 62; n++) begin
            roll = $urandom_range(0, 99);
            if (n % 20 == 0 && $urandom_range(0, 1) == 0) begin
               no_idle = ~no_idle;
            end
            if (roll < 48) begin
               case ($urandom_range(0, 9))
                  0:       bytes = '0;
                  1:       bytes = REQ_W'($urandom_range(0, 65535));
                  2:       bytes = REQ_W'(DEF_MIN_BLOCK_BYTES << $urandom_range(0, 4));
                  default: bytes = REQ_W'($urandom_range(1, DEF_PAGE_BYTES));
               endcase
               issue_request(ACT_ALLOC, bytes, OFF_W'($urandom()));
            end else if (roll < 90) begin
               if (held_blocks.size() != 0 && $urandom_range(0, 4) != 0) begin
                  pick = $urandom_range(0, held_blocks.size() - 1);
                  offset = held_blocks[pick];
                  held_blocks.delete(pick);
               end else begin
                  offset = OFF_W'($urandom_range(0, 2047));
               end
               issue_request(ACT_FREE, REQ_W'($urandom()), offset);
            end else if (roll < 95) begin
               issue_request(ACT_NONE, REQ_W'($urandom()), OFF_W'($urandom()));
            end else begin
               issue_request(ACT_INIT, REQ_W'($urandom()), OFF_W'($urandom()));
            end
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_lists();
      test_class_fit();
      test_full_list();
      test_largest_class();
      test_random_traffic();
      drain();
      repeat (8) @(posedge clock);
      mismatches += awaited_grants.size();
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
